// ----- rtl/l2rs_pkg.sv -----
// Package with shared types, constants and command/status structs of the rational solver.
`default_nettype none
package l2rs_pkg;
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FIELD_W = 16;
    localparam int WIDE_W = 64;

    localparam logic [1:0] ST_UNIQUE = 2'd0;
    localparam logic [1:0] ST_INFINITE = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] x_coef_first;
        logic [FIELD_W-1:0] y_coef_first;
        logic [FIELD_W-1:0] rhs_first;
        logic [FIELD_W-1:0] x_coef_second;
        logic [FIELD_W-1:0] y_coef_second;
        logic [FIELD_W-1:0] rhs_second;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] x_num;
        logic [61:0] x_den;
        logic [32:0] y_num;
        logic [31:0] y_den;
    } t_out_item;

    // Datapath operations selected by the controller.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_GCD_A,
        OP_DIV_A,
        OP_SCALE,
        OP_ELIM,
        OP_GCD_Y,
        OP_DIV_Y,
        OP_BACK,
        OP_GCD_X,
        OP_DIV_X,
        OP_PACK
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic zero_coef;
        logic zy_zero;
        logic zc_zero;
    } t_sts;
endpackage
`default_nettype wire

// ----- rtl/l2rs_divider.sv -----
// Iterative 64-bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module l2rs_divider import l2rs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WIDE_W-1:0] i_dividend,
    input  wire logic [WIDE_W-1:0] i_divisor,
    output logic                   o_busy,
    output logic [WIDE_W-1:0]      o_quot,
    output logic [WIDE_W-1:0]      o_rem
);
    logic [WIDE_W-1:0] r_quot, r_rem, r_div;
    logic [6:0]        r_cnt;
    logic              r_busy;
    logic [WIDE_W:0]   w_trial;
    logic [WIDE_W:0]   w_shift;

    // Shift the next dividend bit in and try a subtraction.
    always_comb begin
        w_shift = {r_rem, r_quot[WIDE_W-1]};
        w_trial = w_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'(WIDE_W);
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[WIDE_W]) begin
                r_rem  <= w_trial[WIDE_W-1:0];
                r_quot <= {r_quot[WIDE_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift[WIDE_W-1:0];
                r_quot <= {r_quot[WIDE_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ----- rtl/l2rs_datapath.sv -----
// Datapath of the rational solver: registers, one multiplier, the divider and gcd loop.
`default_nettype none
module l2rs_datapath import l2rs_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    input  wire t_in_item  i_item,
    output t_sts           o_sts,
    output t_out_item      o_res
);
    localparam int CW = COEF_WIDTH;

    // Signed working registers.
    logic signed [WIDE_W-1:0] r_a0, r_b0, r_c0, r_a1, r_b1, r_c1;
    logic signed [WIDE_W-1:0] r_zy, r_zc, r_yn, r_yd, r_mx, r_mc, r_xn, r_xd;
    logic [WIDE_W-1:0]        r_ga, r_gb;
    logic                     r_zero;
    logic [1:0]               r_phase;
    logic                     r_gbusy;
    t_out_item                r_res;

    logic              w_dstart, w_dbusy;
    logic [WIDE_W-1:0] w_dvd, w_dvs, w_quot, w_rem;
    logic [WIDE_W-1:0] w_abs_n, w_abs_d;
    logic signed [WIDE_W-1:0] w_sq;

    l2rs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_dbusy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    function automatic logic signed [WIDE_W-1:0] sext(input logic [FIELD_W-1:0] v);
        logic signed [CW-1:0] t;
        t = v[CW-1:0];
        return WIDE_W'(t);
    endfunction

    function automatic logic [WIDE_W-1:0] absv(input logic signed [WIDE_W-1:0] v);
        return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    endfunction

    // Select numerator and denominator of the fraction under reduction.
    always_comb begin
        case (i_cmd.op)
            OP_DIV_A: begin
                w_abs_n = absv(r_a1);
                w_abs_d = absv(r_a0);
            end
            OP_GCD_Y, OP_DIV_Y: begin
                w_abs_n = absv(r_zc);
                w_abs_d = absv(r_zy);
            end
            OP_GCD_X, OP_DIV_X: begin
                w_abs_n = absv(r_mc);
                w_abs_d = absv(r_mx);
            end
            default: begin
                w_abs_n = '0;
                w_abs_d = '0;
            end
        endcase
    end

    // Divider feeds: gcd step uses remainders, division steps use the gcd.
    always_comb begin
        w_dstart = 1'b0;
        w_dvd    = r_ga;
        w_dvs    = r_gb;
        case (i_cmd.op)
            OP_GCD_A, OP_GCD_Y, OP_GCD_X: begin
                w_dstart = r_gbusy && !w_dbusy && (r_phase == 2'd1) && (r_gb != '0);
            end
            OP_DIV_A, OP_DIV_Y, OP_DIV_X: begin
                w_dstart = r_gbusy && !w_dbusy && ((r_phase == 2'd0) || (r_phase == 2'd1));
                w_dvd    = (r_phase == 2'd1) ? r_gb : w_abs_n;
                w_dvs    = r_ga;
            end
            default: ;
        endcase
    end

    // Shared multiplier, one product per cycle; operands stay within 32 by 33 bits.
    logic signed [31:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [64:0] w_prod;
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_SCALE: begin
                case (r_phase)
                    2'd0: begin w_ma = r_b0[31:0]; w_mb = r_zy[32:0]; end
                    2'd1: begin w_ma = r_c0[31:0]; w_mb = r_zy[32:0]; end
                    2'd2: begin w_ma = r_b1[31:0]; w_mb = r_zc[32:0]; end
                    default: begin w_ma = r_c1[31:0]; w_mb = r_zc[32:0]; end
                endcase
            end
            OP_ELIM: begin
                w_ma = r_a0[31:0];
                w_mb = r_zy[32:0];
            end
            OP_BACK: begin
                case (r_phase)
                    2'd0: begin w_ma = r_a0[31:0]; w_mb = r_yd[32:0]; end
                    2'd1: begin w_ma = r_c0[31:0]; w_mb = r_yd[32:0]; end
                    default: begin w_ma = r_b0[31:0]; w_mb = r_yn[32:0]; end
                endcase
            end
            default: ;
        endcase
        w_prod = w_ma * w_mb;
        w_sq   = w_prod[WIDE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gbusy <= 1'b0;
            r_phase <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_a0 <= i_item.x_coef_first[CW-1] ? -sext(i_item.x_coef_first)
                                                      : sext(i_item.x_coef_first);
                    r_b0 <= i_item.x_coef_first[CW-1] ? -sext(i_item.y_coef_first)
                                                      : sext(i_item.y_coef_first);
                    r_c0 <= i_item.x_coef_first[CW-1] ? -sext(i_item.rhs_first)
                                                      : sext(i_item.rhs_first);
                    r_a1 <= i_item.x_coef_second[CW-1] ? -sext(i_item.x_coef_second)
                                                       : sext(i_item.x_coef_second);
                    r_b1 <= i_item.x_coef_second[CW-1] ? -sext(i_item.y_coef_second)
                                                       : sext(i_item.y_coef_second);
                    r_c1 <= i_item.x_coef_second[CW-1] ? -sext(i_item.rhs_second)
                                                       : sext(i_item.rhs_second);
                    r_zero <= (i_item.x_coef_first[CW-1:0] == '0)
                           || (i_item.y_coef_first[CW-1:0] == '0)
                           || (i_item.x_coef_second[CW-1:0] == '0)
                           || (i_item.y_coef_second[CW-1:0] == '0);
                    r_res   <= '0;
                    r_gbusy <= 1'b0;
                end
                OP_GCD_A, OP_GCD_Y, OP_GCD_X: begin
                    // Euclid loop: the start loads, phase 1 issues a step or ends the loop, 2 waits for it.
                    if (i_cmd.start) begin
                        r_gbusy <= 1'b1;
                        r_phase <= 2'd1;
                        if (i_cmd.op == OP_GCD_A) begin
                            r_ga <= r_a0;
                            r_gb <= r_a1;
                        end else begin
                            r_ga <= w_abs_d;
                            r_gb <= w_abs_n;
                        end
                    end else if (r_phase == 2'd1) begin
                        if (r_gb == '0) begin
                            r_gbusy <= 1'b0;
                            r_phase <= 2'd0;
                        end else begin
                            r_phase <= 2'd2;
                        end
                    end else if (r_phase == 2'd2 && !w_dbusy) begin
                        r_ga    <= r_gb;
                        r_gb    <= w_rem;
                        r_phase <= 2'd1;
                    end
                end
                OP_DIV_A, OP_DIV_Y, OP_DIV_X: begin
                    // Two quotients by the gcd in r_ga: numerator side first.
                    if (i_cmd.start) begin
                        r_gbusy <= 1'b1;
                        r_phase <= 2'd0;
                        if (i_cmd.op == OP_DIV_A) begin
                            r_gb <= WIDE_W'(r_a0);
                        end else begin
                            r_gb <= w_abs_d;
                        end
                    end else if (!w_dbusy && r_gbusy) begin
                        if (r_phase == 2'd0) begin
                            r_phase <= 2'd2;
                        end else if (r_phase == 2'd2) begin
                            r_phase <= 2'd1;
                            // The numerator takes the sign of the whole fraction.
                            case (i_cmd.op)
                                OP_DIV_A: r_zy <= w_quot;
                                OP_DIV_Y: r_yn <= (r_zc[WIDE_W-1] ^ r_zy[WIDE_W-1])
                                                  ? -w_quot : w_quot;
                                default:  r_xn <= (r_mc[WIDE_W-1] ^ r_mx[WIDE_W-1])
                                                  ? -w_quot : w_quot;
                            endcase
                        end else if (r_phase == 2'd1) begin
                            r_phase <= 2'd3;
                        end else begin
                            r_gbusy <= 1'b0;
                            r_phase <= 2'd0;
                            case (i_cmd.op)
                                // d0 = a1/g (held in r_zy), d1 = a0/g.
                                OP_DIV_A: r_zc <= w_quot;
                                OP_DIV_Y: r_yd <= w_quot;
                                default:  r_xd <= w_quot;
                            endcase
                        end
                    end
                end
                OP_SCALE: begin
                    // Products: B0=b0*d0, C0=c0*d0, B1=b1*d1, C1=c1*d1.
                    r_phase <= r_phase + 2'd1;
                    case (r_phase)
                        2'd0: r_b0 <= w_sq;
                        2'd1: r_c0 <= w_sq;
                        2'd2: r_b1 <= w_sq;
                        default: r_c1 <= w_sq;
                    endcase
                    if (r_phase == 2'd0) begin
                        r_a0 <= r_a0;
                    end
                end
                OP_ELIM: begin
                    // Eliminate x; the common x coefficient A = a0*d0 is formed alongside.
                    r_phase <= '0;
                    r_zy <= r_b0 - r_b1;
                    r_zc <= r_c0 - r_c1;
                    r_a0 <= w_sq;
                end
                OP_BACK: begin
                    r_phase <= (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
                    case (r_phase)
                        2'd0: r_mx <= w_sq;
                        2'd1: r_mc <= w_sq;
                        default: r_mc <= r_mc - w_sq;
                    endcase
                end
                OP_PACK: begin
                    r_phase <= '0;
                    if (r_zero) begin
                        r_res.status <= ST_INVALID;
                    end else if (r_zy == '0) begin
                        r_res.status <= (r_zc == '0) ? ST_INFINITE : ST_NONE;
                    end else begin
                        r_res.status <= ST_UNIQUE;
                        r_res.x_num  <= r_xn;
                        r_res.x_den  <= r_xd[61:0];
                        r_res.y_num  <= r_yn[32:0];
                        r_res.y_den  <= r_yd[31:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.busy      = r_gbusy || w_dbusy || i_cmd.start;
    assign o_sts.zero_coef = r_zero;
    assign o_sts.zy_zero   = (r_zy == '0);
    assign o_sts.zc_zero   = (r_zc == '0);
    assign o_res           = r_res;
endmodule
`default_nettype wire

// ----- rtl/l2rs_ctrl.sv -----
// Controller state machine that sequences the solver datapath.
`default_nettype none
module l2rs_ctrl import l2rs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_stall,
    output logic      o_out_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_GCD_A, S_DIV_A, S_SCALE, S_ELIM, S_GCD_Y, S_DIV_Y,
        S_BACK, S_GCD_X, S_DIV_X, S_PACK, S_OUT
    } t_state;

    t_state    r_state, n_state;
    logic      r_start, n_start;
    logic [1:0] r_cnt, n_cnt;
    logic      r_out_valid, n_out_valid;

    // Command decode from the current state.
    always_comb begin
        o_cmd.start = r_start;
        case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NOP;
            S_GCD_A: o_cmd.op = OP_GCD_A;
            S_DIV_A: o_cmd.op = OP_DIV_A;
            S_SCALE: o_cmd.op = OP_SCALE;
            S_ELIM:  o_cmd.op = OP_ELIM;
            S_GCD_Y: o_cmd.op = OP_GCD_Y;
            S_DIV_Y: o_cmd.op = OP_DIV_Y;
            S_BACK:  o_cmd.op = OP_BACK;
            S_GCD_X: o_cmd.op = OP_GCD_X;
            S_DIV_X: o_cmd.op = OP_DIV_X;
            S_PACK:  o_cmd.op = OP_PACK;
            default: o_cmd.op = OP_NOP;
        endcase
    end

    // Next state and registered outputs.
    always_comb begin
        n_state     = r_state;
        n_start     = 1'b0;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        case (r_state)
            S_IDLE: if (i_in_valid) begin
                n_state = S_GCD_A;
                n_start = 1'b1;
            end
            S_GCD_A: if (!r_start && !i_sts.busy) begin
                if (i_sts.zero_coef) begin
                    n_state = S_PACK;
                end else begin
                    n_state = S_DIV_A;
                    n_start = 1'b1;
                end
            end
            S_DIV_A: if (!r_start && !i_sts.busy) begin
                n_state = S_SCALE;
                n_cnt   = '0;
            end
            S_SCALE: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) n_state = S_ELIM;
            end
            S_ELIM: begin
                n_state = S_GCD_Y;
                n_start = 1'b1;
            end
            // The gcd always runs to its end so that the divider is idle afterwards.
            S_GCD_Y: if (!r_start && !i_sts.busy) begin
                if (i_sts.zy_zero) begin
                    n_state = S_PACK;
                end else begin
                    n_state = S_DIV_Y;
                    n_start = 1'b1;
                end
            end
            S_DIV_Y: if (!r_start && !i_sts.busy) begin
                n_state = S_BACK;
                n_cnt   = '0;
            end
            S_BACK: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_state = S_GCD_X;
                    n_start = 1'b1;
                end
            end
            S_GCD_X: if (!r_start && !i_sts.busy) begin
                n_state = S_DIV_X;
                n_start = 1'b1;
            end
            S_DIV_X: if (!r_start && !i_sts.busy) begin
                n_state = S_PACK;
            end
            S_PACK: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
            end
            S_OUT: if (!i_out_stall) begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ----- rtl/linear_2x2_exact_rational_solver_core.sv -----
// Top level of the exact rational solver for two linear equations.
//
//  channel | handshake                  | payload
//  input   | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//  output  | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//
// One item is in flight at a time. The gcd and division steps run through the shared 64-bit
// radix-2 divider. A unique solve runs all three gcds; a zero coefficient ends after the
// first gcd, a degenerate system after the second.
// Reset is synchronous and active low; the block is idle right after it.
// A result waits in its register while the output is stalled, and input stays stalled.
`default_nettype none
module linear_2x2_exact_rational_solver_core import l2rs_pkg::*; #(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item
);
    t_cmd w_cmd;
    t_sts w_sts;

    l2rs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    l2rs_datapath #(.COEF_WIDTH(COEF_WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_in_item),
        .o_sts   (w_sts),
        .o_res   (o_out_item)
    );

`ifndef SYNTH
    // No new item is taken while a result is still offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input taken while result pending");
    // A stalled result keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_item))
        else $error("result changed under stall");
    // A reported unique solution never has a zero y denominator.
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_UNIQUE) |->
        (o_out_item.y_den != '0)) else $error("zero denominator");
`endif
endmodule
`default_nettype wire
